@@ rtl/jdc_pkg.sv @@
// Shared types and constants for the Julian date to calendar converter.
package jdc_pkg;

  localparam int NumStages  = 15;
  localparam int TimeStages = 8;
  localparam int YearW      = 17;

  typedef logic [NumStages-1:0] stage_en_t;

  typedef struct packed {
    logic signed [YearW-1:0] year;
    logic [3:0]              month;
    logic [4:0]              day_of_month;
  } cal_date_t;

  typedef struct packed {
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [21:0] second_q16;
  } tod_t;

endpackage

@@ rtl/jdc_date.sv @@
// Day number to Gregorian year, month and day pipeline.
module jdc_date #(
  parameter int DAY_BITS = 24
) (
  input  logic                     clk,
  input  jdc_pkg::stage_en_t       en,
  input  logic [DAY_BITS-1:0]      day_num,
  input  logic                     round_up,
  output jdc_pkg::cal_date_t       cal
);

  localparam int YW   = jdc_pkg::YearW;
  localparam int DivN = 146097;
  localparam int DivI = 1461001;
  localparam int DivJ = 2447;

  localparam int JW   = DAY_BITS + 1;
  localparam int A1W  = DAY_BITS + 3;
  localparam int M1W  = A1W - 17;
  localparam int P1W  = A1W + M1W;
  localparam int R1W  = 19;
  localparam int L1W  = 18;
  localparam int A2W  = 30;
  localparam int M2W  = 10;
  localparam int P2W  = A2W + M2W;
  localparam int IW   = P2W - A2W;
  localparam int R2W  = 22;
  localparam int IPW  = 21;
  localparam int L2W  = 10;
  localparam int A3W  = 17;
  localparam int M3W  = 6;
  localparam int P3W  = A3W + M3W;
  localparam int JQW  = P3W - A3W;
  localparam int R3W  = 13;
  localparam int JSW  = 4;

  localparam logic [M1W-1:0] M1 = M1W'((64'd1 << A1W) / DivN);
  localparam logic [M2W-1:0] M2 = M2W'((64'd1 << A2W) / DivI);
  localparam logic [M3W-1:0] M3 = M3W'((64'd1 << A3W) / DivJ);

  function automatic logic [8:0] day_offset(input logic [JSW-1:0] j);
    logic [8:0] v;
    unique case (j)
      4'd0:  v = 9'd0;
      4'd1:  v = 9'd30;
      4'd2:  v = 9'd61;
      4'd3:  v = 9'd91;
      4'd4:  v = 9'd122;
      4'd5:  v = 9'd152;
      4'd6:  v = 9'd183;
      4'd7:  v = 9'd214;
      4'd8:  v = 9'd244;
      4'd9:  v = 9'd275;
      4'd10: v = 9'd305;
      4'd11: v = 9'd336;
      4'd12: v = 9'd367;
      4'd13: v = 9'd397;
      4'd14: v = 9'd428;
      4'd15: v = 9'd458;
    endcase
    return v;
  endfunction

  logic [JW-1:0]  l0_s1, l0_s2, l0_s3, l0_s4;
  logic [P1W-1:0] p1_s2;
  logic [M1W-1:0] n0_s3, n_s4;
  logic [R1W-1:0] r1_s3;
  logic [L1W-1:0] l1_s5, l1_s6, l1_s7, l1_s8, l1_s9;
  logic [YW-1:0]  y0_s5, y0_s6, y0_s7, y0_s8, y0_s9, y0_s10, y0_s11, y0_s12, y0_s13, y0_s14;
  logic [A2W-1:0] a2_s6, a2_s7;
  logic [P2W-1:0] p2_s7;
  logic [IW-1:0]  i0_s8, i_s9, i_s10, i_s11, i_s12, i_s13, i_s14;
  logic [R2W-1:0] r2_s8;
  logic [L2W-1:0] l2_s10, l2_s11, l2_s12, l2_s13, l2_s14;
  logic [A3W-1:0] a3_s11, a3_s12;
  logic [P3W-1:0] p3_s12;
  logic [JQW-1:0] j0_s13;
  logic [R3W-1:0] r3_s13;
  logic [JSW-1:0] j_s14;

  logic [M1W-1:0] n0_c;
  logic [A1W-1:0] n0_prod, n_prod;
  logic [IW-1:0]  i0_c;
  logic [IPW-1:0] i_prod;
  logic [JQW-1:0] j0_c;
  logic           lc;

  assign n0_c    = p1_s2[P1W-1:A1W];
  assign n0_prod = A1W'(n0_c) * A1W'(DivN);
  assign n_prod  = A1W'(n_s4) * A1W'(DivN) + A1W'(3);
  assign i0_c    = p2_s7[P2W-1:A2W];
  assign i_prod  = IPW'(i_s9) * IPW'(1461);
  assign j0_c    = p3_s12[P3W-1:A3W];
  assign lc      = (j_s14 >= 4'd11);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      l0_s1 <= JW'(day_num) + JW'(round_up) + JW'(68569);
    end
    if (en[1]) begin
      l0_s2 <= l0_s1;
      p1_s2 <= P1W'({l0_s1, 2'b00}) * P1W'(M1);
    end
    if (en[2]) begin
      l0_s3 <= l0_s2;
      n0_s3 <= n0_c;
      r1_s3 <= R1W'({l0_s2, 2'b00} - n0_prod);
    end
    if (en[3]) begin
      l0_s4 <= l0_s3;
      n_s4  <= n0_s3 + M1W'(r1_s3 >= R1W'(DivN));
    end
    if (en[4]) begin
      l1_s5 <= L1W'(A1W'(l0_s4) - (n_prod >> 2));
      y0_s5 <= YW'(n_s4) * YW'(100) - YW'(4900);
    end
    if (en[5]) begin
      l1_s6 <= l1_s5;
      y0_s6 <= y0_s5;
      a2_s6 <= (A2W'(l1_s5) + A2W'(1)) * A2W'(4000);
    end
    if (en[6]) begin
      l1_s7 <= l1_s6;
      y0_s7 <= y0_s6;
      a2_s7 <= a2_s6;
      p2_s7 <= P2W'(a2_s6) * P2W'(M2);
    end
    if (en[7]) begin
      l1_s8 <= l1_s7;
      y0_s8 <= y0_s7;
      i0_s8 <= i0_c;
      r2_s8 <= R2W'(a2_s7 - A2W'(i0_c) * A2W'(DivI));
    end
    if (en[8]) begin
      l1_s9 <= l1_s8;
      y0_s9 <= y0_s8;
      i_s9  <= i0_s8 + IW'(r2_s8 >= R2W'(DivI));
    end
    if (en[9]) begin
      y0_s10 <= y0_s9;
      i_s10  <= i_s9;
      l2_s10 <= L2W'(IPW'(l1_s9) - (i_prod >> 2) + IPW'(31));
    end
    if (en[10]) begin
      y0_s11 <= y0_s10;
      i_s11  <= i_s10;
      l2_s11 <= l2_s10;
      a3_s11 <= A3W'(l2_s10) * A3W'(80);
    end
    if (en[11]) begin
      y0_s12 <= y0_s11;
      i_s12  <= i_s11;
      l2_s12 <= l2_s11;
      a3_s12 <= a3_s11;
      p3_s12 <= P3W'(a3_s11) * P3W'(M3);
    end
    if (en[12]) begin
      y0_s13 <= y0_s12;
      i_s13  <= i_s12;
      l2_s13 <= l2_s12;
      j0_s13 <= j0_c;
      r3_s13 <= R3W'(a3_s12 - A3W'(j0_c) * A3W'(DivJ));
    end
    if (en[13]) begin
      y0_s14 <= y0_s13;
      i_s14  <= i_s13;
      l2_s14 <= l2_s13;
      j_s14  <= JSW'(j0_s13 + JQW'(r3_s13 >= R3W'(DivJ)));
    end
    if (en[14]) begin
      cal.year         <= $signed(y0_s14 + YW'(i_s14) + YW'(lc));
      cal.month        <= lc ? (j_s14 - 4'd10) : (j_s14 + 4'd2);
      cal.day_of_month <= 5'(l2_s14 - L2W'(day_offset(j_s14)));
    end
  end

endmodule

@@ rtl/jdc_time.sv @@
// Day fraction to hour, minute and fixed-point seconds pipeline.
module jdc_time #(
  parameter int FRAC_BITS = 32
) (
  input  logic                 clk,
  input  jdc_pkg::stage_en_t   en,
  input  logic [FRAC_BITS-1:0] frac,
  output jdc_pkg::tod_t        tod
);

  localparam int NS        = jdc_pkg::NumStages;
  localparam int TS        = jdc_pkg::TimeStages;
  localparam int DlyN      = NS - TS;
  localparam int SPW       = FRAC_BITS + 17;
  localparam int TW        = 17;
  localparam int PW        = 29;
  localparam int MW        = 11;
  localparam int PMW       = 17;
  localparam int SecPerMin = 60;
  localparam int Recip60   = (1 << TW) / SecPerMin;
  localparam int Recip60m  = (1 << MW) / SecPerMin;

  logic [FRAC_BITS-1:0] f_s1;
  logic [SPW-1:0]       sp_s2;
  logic [TW-1:0]        t_s3;
  logic [15:0]          sf_s3, sf_s4, sf_s5, sf_s6, sf_s7;
  logic [PW-1:0]        p_s3;
  logic [MW-1:0]        tm0_s4, tm_s5, tm_s6;
  logic [6:0]           r_s4, rm_s7;
  logic [5:0]           sec_s5, sec_s6, sec_s7;
  logic [PMW-1:0]       pm_s6;
  logic [4:0]           h0_s7;
  jdc_pkg::tod_t        dly [DlyN];

  logic [TW-1:0] t_c;
  logic [MW-1:0] tm0_c;
  logic [4:0]    h0_c;
  logic          sc, mc;

  assign t_c   = sp_s2[FRAC_BITS +: TW];
  assign tm0_c = p_s3[TW +: MW];
  assign h0_c  = pm_s6[MW +: 5];
  assign sc    = (r_s4 >= 7'(SecPerMin));
  assign mc    = (rm_s7 >= 7'(SecPerMin));

  always_ff @(posedge clk) begin
    if (en[0]) begin
      f_s1 <= {~frac[FRAC_BITS-1], frac[FRAC_BITS-2:0]};
    end
    if (en[1]) begin
      sp_s2 <= SPW'(f_s1) * SPW'(86400);
    end
    if (en[2]) begin
      t_s3  <= t_c;
      sf_s3 <= sp_s2[FRAC_BITS-16 +: 16];
      p_s3  <= PW'(t_c) * PW'(Recip60);
    end
    if (en[3]) begin
      sf_s4  <= sf_s3;
      tm0_s4 <= tm0_c;
      r_s4   <= 7'(t_s3 - TW'(tm0_c) * TW'(SecPerMin));
    end
    if (en[4]) begin
      sf_s5  <= sf_s4;
      tm_s5  <= tm0_s4 + MW'(sc);
      sec_s5 <= 6'(sc ? (r_s4 - 7'(SecPerMin)) : r_s4);
    end
    if (en[5]) begin
      sf_s6  <= sf_s5;
      sec_s6 <= sec_s5;
      tm_s6  <= tm_s5;
      pm_s6  <= PMW'(tm_s5) * PMW'(Recip60m);
    end
    if (en[6]) begin
      sf_s7  <= sf_s6;
      sec_s7 <= sec_s6;
      h0_s7  <= h0_c;
      rm_s7  <= 7'(tm_s6 - MW'(h0_c) * MW'(SecPerMin));
    end
    if (en[7]) begin
      dly[0].hour       <= h0_s7 + 5'(mc);
      dly[0].minute     <= 6'(mc ? (rm_s7 - 7'(SecPerMin)) : rm_s7);
      dly[0].second_q16 <= {sec_s7, sf_s7};
    end
  end

  for (genvar k = 1; k < DlyN; k++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en[TS + k - 1]) begin
        dly[k] <= dly[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      tod <= dly[DlyN-1];
    end
  end

endmodule

@@ rtl/julian_date_to_calendar.sv @@
// Julian date to Gregorian date and time of day converter, top level.
// Throughput: one transaction per cycle unless the output stalls with every
// stage full, set by the 15-stage pipeline of constant-reciprocal multiplies
// with one remainder correction per division. Empty stages collapse, so input
// is taken while a result waits at the output, as long as a stage is empty.
// Reset clears only the stage valid bits; data registers are not reset.
module julian_date_to_calendar #(
  parameter int DAY_BITS  = 24,
  parameter int FRAC_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          jd_valid,
  output logic                          jd_stall,
  input  logic [DAY_BITS+FRAC_BITS-1:0] julian_date,
  output logic                          cal_valid,
  input  logic                          cal_stall,
  output logic signed [16:0]            year,
  output logic [3:0]                    month,
  output logic [4:0]                    day_of_month,
  output logic [4:0]                    hour,
  output logic [5:0]                    minute,
  output logic [21:0]                   second_q16
);

  localparam int NS = jdc_pkg::NumStages;

  logic [NS-1:0]      valid;
  jdc_pkg::stage_en_t en;
  jdc_pkg::cal_date_t cal;
  jdc_pkg::tod_t      tod;

  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = ~cal_stall | ~(&valid[NS-1:k]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) begin
        valid[0] <= jd_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  assign jd_stall  = ~en[0];
  assign cal_valid = valid[NS-1];

  jdc_date #(
    .DAY_BITS(DAY_BITS)
  ) u_date (
    .clk      (clk),
    .en       (en),
    .day_num  (julian_date[DAY_BITS+FRAC_BITS-1:FRAC_BITS]),
    .round_up (julian_date[FRAC_BITS-1]),
    .cal      (cal)
  );

  jdc_time #(
    .FRAC_BITS(FRAC_BITS)
  ) u_time (
    .clk  (clk),
    .en   (en),
    .frac (julian_date[FRAC_BITS-1:0]),
    .tod  (tod)
  );

  assign year         = cal.year;
  assign month        = cal.month;
  assign day_of_month = cal.day_of_month;
  assign hour         = tod.hour;
  assign minute       = tod.minute;
  assign second_q16   = tod.second_q16;

  a_no_stall_with_room: assert property (@(posedge clk) disable iff (rst)
    !(&valid) |-> !jd_stall)
    else $error("input stalled while the pipeline has an empty stage");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    valid[NS-2] && en[NS-1] |=> cal_valid)
    else $error("transaction lost entering the output stage");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    cal_valid |-> (month >= 4'd1 && month <= 4'd12 &&
                   day_of_month >= 5'd1 && day_of_month <= 5'd31))
    else $error("month or day out of range");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    cal_valid |-> (hour < 5'd24 && minute < 6'd60 && second_q16 < 22'd3932160))
    else $error("time of day out of range");

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the Julian date to calendar converter.
module testbench;

  localparam int DayBits   = 24;
  localparam int FracBits  = 32;
  localparam int InW       = DayBits + FracBits;
  localparam int CycleCap  = 400000;
  localparam int DrainWait = 40;
  localparam int HoldStart = 150;
  localparam int HoldLen   = 300;

  typedef struct packed {
    jdc_pkg::cal_date_t date;
    jdc_pkg::tod_t      tod;
  } calendar_point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic jd_valid = 1'b0;
  logic jd_stall;
  logic [InW-1:0] julian_date = '0;
  logic cal_valid;
  logic cal_stall = 1'b0;
  logic signed [16:0] year;
  logic [3:0] month;
  logic [4:0] day_of_month;
  logic [4:0] hour;
  logic [5:0] minute;
  logic [21:0] second_q16;

  logic [InW-1:0] pending_dates[$];
  calendar_point_t expected_dates[$];
  calendar_point_t want;
  int error_count = 0;
  int checked_count = 0;
  int cycle_count = 0;
  int tx_gap = 0;
  int rx_wait = 0;
  int hold_cycles = 0;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  logic hold_off = 1'b0;
  logic hold_done = 1'b0;

  julian_date_to_calendar #(
    .DAY_BITS (DayBits),
    .FRAC_BITS(FracBits)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .jd_valid    (jd_valid),
    .jd_stall    (jd_stall),
    .julian_date (julian_date),
    .cal_valid   (cal_valid),
    .cal_stall   (cal_stall),
    .year        (year),
    .month       (month),
    .day_of_month(day_of_month),
    .hour        (hour),
    .minute      (minute),
    .second_q16  (second_q16)
  );

  function automatic calendar_point_t gregorian_of(input logic [InW-1:0] jd);
    logic [FracBits-1:0] since_midnight;
    longint unsigned day_num;
    longint unsigned secs;
    longint l, n, i, j, d, m, y;
    calendar_point_t r;
    day_num = jd[InW-1:FracBits] + jd[FracBits-1];
    since_midnight = jd[FracBits-1:0] + {1'b1, {(FracBits-1){1'b0}}};
    l = longint'(day_num) + 68569;
    n = (4 * l) / 146097;
    l = l - (146097 * n + 3) / 4;
    i = (4000 * (l + 1)) / 1461001;
    l = l - (1461 * i) / 4 + 31;
    j = (80 * l) / 2447;
    d = l - (2447 * j) / 80;
    l = j / 11;
    m = j + 2 - 12 * l;
    y = 100 * (n - 49) + i + l;
    secs = (longint'(since_midnight) * 86400) >> (FracBits - 16);
    r.date.year = y[16:0];
    r.date.month = m[3:0];
    r.date.day_of_month = d[4:0];
    r.tod.hour = 5'(secs / 235929600);
    r.tod.minute = 6'((secs / 3932160) % 60);
    r.tod.second_q16 = 22'(secs % 3932160);
    return r;
  endfunction

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleCap) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Sender: offer queued dates, hold a stalled transaction, idle for random gaps between items.
  always @(posedge clk) begin
    if (rst) begin
      jd_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (jd_valid && !jd_stall)
        expected_dates.push_back(gregorian_of(julian_date));
      if (!jd_valid || !jd_stall) begin
        if (tx_gap > 0) begin
          tx_gap--;
          jd_valid <= 1'b0;
        end else if (pending_dates.size() > 0) begin
          julian_date <= pending_dates.pop_front();
          jd_valid <= 1'b1;
          if ($urandom_range(0, 49) == 0) tx_quiet = !tx_quiet;
          tx_gap = tx_quiet ? 0 : $urandom_range(0, 17);
        end else begin
          jd_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each transaction against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      cal_stall <= 1'b0;
      rx_wait = 0;
    end else begin
      if (cal_valid && !cal_stall) begin
        checked_count++;
        if (expected_dates.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result %0d-%0d-%0d %0d:%0d sec_q16 %0d", $time,
                   year, month, day_of_month, hour, minute, second_q16);
        end else begin
          want = expected_dates.pop_front();
          if ({year, month, day_of_month, hour, minute, second_q16} !== want) begin
            error_count++;
            $display("%0t: expected %0d-%0d-%0d %0d:%0d sq %0d, actual %0d-%0d-%0d %0d:%0d sq %0d",
                     $time,
                     want.date.year, want.date.month, want.date.day_of_month,
                     want.tod.hour, want.tod.minute, want.tod.second_q16,
                     year, month, day_of_month, hour, minute, second_q16);
          end
        end
        if ($urandom_range(0, 49) == 0) rx_quiet = !rx_quiet;
        rx_wait = rx_quiet ? 0 : $urandom_range(0, 17);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      cal_stall <= hold_off || (rx_wait > 0);
    end
  end

  // Hold off the output once for a long stretch so the pipeline backs up.
  always @(posedge clk) begin
    if (rst) begin
      hold_off <= 1'b0;
      hold_done <= 1'b0;
      hold_cycles <= 0;
    end else if (!hold_done && !hold_off && checked_count >= HoldStart) begin
      hold_off <= 1'b1;
      hold_cycles <= HoldLen;
    end else if (hold_off) begin
      if (hold_cycles == 1) begin
        hold_off <= 1'b0;
        hold_done <= 1'b1;
      end
      hold_cycles <= hold_cycles - 1;
    end
  end

  initial begin
    logic [InW-1:0] jd;
    logic [DayBits-1:0] days;
    logic [FracBits-1:0] frac;
    pending_dates.push_back('0);
    pending_dates.push_back('1);
    pending_dates.push_back({24'd0, 32'h7FFF_FFFF});
    pending_dates.push_back({24'd0, 32'h8000_0000});
    pending_dates.push_back({24'hFF_FFFF, 32'h7FFF_FFFF});
    pending_dates.push_back({24'hFF_FFFE, 32'h8000_0000});
    pending_dates.push_back({24'hFF_FFFF, 32'h0000_0000});
    pending_dates.push_back({24'd2451544, 32'h8000_0000});
    pending_dates.push_back({24'd2451543, 32'hFFFF_FFFF});
    pending_dates.push_back({24'd2451604, 32'h8000_0000});
    pending_dates.push_back({24'd2451605, 32'h8000_0000});
    pending_dates.push_back({24'd2415078, 32'h8000_0000});
    pending_dates.push_back({24'd2415079, 32'h8000_0000});
    pending_dates.push_back({24'd2299160, 32'h8000_0000});
    pending_dates.push_back({24'd2459580, 32'h7FFF_FFFF});
    pending_dates.push_back({24'd2459580, 32'h0000_0000});
    pending_dates.push_back({24'd2459580, 32'h4000_0000});
    pending_dates.push_back({24'd2459580, 32'hC000_0000});
    pending_dates.push_back({24'd1721425, 32'h8000_0000});
    pending_dates.push_back({24'd1721424, 32'h8000_0000});
    pending_dates.push_back({24'd2460000, 32'h8000_0001});
    pending_dates.push_back({24'hAA_AAAA, 32'h5555_5555});
    pending_dates.push_back({24'h55_5555, 32'hAAAA_AAAA});
    repeat (1500) begin
      frac = $urandom;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: jd = InW'({$urandom, $urandom});
        4, 5, 6: jd = {24'($urandom_range(2000000, 2800000)), frac};
        7: begin
          days = DayBits'($urandom);
          frac = 32'h8000_0000 + 32'($urandom_range(0, 8)) - 32'd4;
          jd = {days, frac};
        end
        8: jd = {24'($urandom_range(0, 200000)), frac};
        default: jd = {24'hFF_FFFF - 24'($urandom_range(0, 100000)), frac};
      endcase
      pending_dates.push_back(jd);
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    while (pending_dates.size() > 0 || jd_valid) @(posedge clk);
    while (expected_dates.size() > 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/jdc_pkg.sv
rtl/jdc_date.sv
rtl/jdc_time.sv
rtl/julian_date_to_calendar.sv
test/testbench.sv
